@@ rtl/core/pidisd_pkg.sv @@
// ----------------------------------------------------------------------------
// pidisd_pkg
// Shared register indexes, field widths, reset values and the configuration
// bundle for the PID controller with integral separation and dead band.
// ----------------------------------------------------------------------------
package pidisd_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_WINDOW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_BOUND  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_BOUND     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND       = 3'd6;

    // field widths
    localparam int GAIN_W   = 16;
    localparam int WINDOW_W = 16;
    localparam int BOUND_W  = 15;
    localparam int DRIVE_W  = 16;

    // reset values
    localparam logic [GAIN_W-1:0]   GAIN_RST   = 16'd0;
    localparam logic [WINDOW_W-1:0] WINDOW_RST = 16'hFFFF;
    localparam logic [BOUND_W-1:0]  BOUND_RST  = 15'h7FFF;
    localparam logic [BOUND_W-1:0]  DEAD_RST   = 15'd0;

    typedef struct packed {
        logic [GAIN_W-1:0]   gain_p;
        logic [GAIN_W-1:0]   gain_i;
        logic [GAIN_W-1:0]   gain_d;
        logic [WINDOW_W-1:0] integral_window;
        logic [BOUND_W-1:0]  integral_bound;
        logic [BOUND_W-1:0]  drive_bound;
        logic [BOUND_W-1:0]  dead_band;
    } cfg_t;

endpackage

@@ rtl/core/pidisd_terms.sv @@
// ----------------------------------------------------------------------------
// pidisd_terms
// Forms the P and D products and updates the integral accumulator with
// separation window and symmetric clamp. Holds the controller state.
// ----------------------------------------------------------------------------
module pidisd_terms
    import pidisd_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load,
    input  logic signed [DATA_WIDTH:0]        err,
    input  cfg_t                              cfg,
    output logic signed [DATA_WIDTH+GAIN_W+1:0] p_term,
    output logic signed [DATA_WIDTH+GAIN_W+2:0] d_term,
    output logic signed [BOUND_W+FRAC_BITS:0] i_term
);

    localparam int E_W   = DATA_WIDTH + 1;
    localparam int DF_W  = DATA_WIDTH + 2;
    localparam int P_W   = E_W + GAIN_W + 1;
    localparam int DP_W  = DF_W + GAIN_W + 1;
    localparam int ACC_W = BOUND_W + FRAC_BITS + 1;
    localparam int IP_W  = ((ACC_W > P_W) ? ACC_W : P_W) + 1;
    localparam int MW    = (E_W > WINDOW_W) ? E_W : WINDOW_W;

    logic signed [E_W-1:0]   prev_reg;
    logic signed [E_W-1:0]   prev_next;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [P_W-1:0]   p_reg;
    logic signed [DP_W-1:0]  d_reg;

    logic signed [GAIN_W:0]  gp_s;
    logic signed [GAIN_W:0]  gi_s;
    logic signed [GAIN_W:0]  gd_s;
    logic signed [DF_W-1:0]  err_diff;
    logic signed [P_W-1:0]   p_prod;
    logic signed [P_W-1:0]   i_prod;
    logic signed [DP_W-1:0]  d_prod;
    logic        [E_W-1:0]   err_mag;
    logic                    in_window;
    logic signed [IP_W-1:0]  acc_sum;
    logic signed [IP_W-1:0]  acc_pre;
    logic signed [ACC_W-1:0] ilim;
    logic signed [IP_W-1:0]  ilim_w;
    logic signed [ACC_W-1:0] acc_clamped;

    assign gp_s = $signed({1'b0, cfg.gain_p});
    assign gi_s = $signed({1'b0, cfg.gain_i});
    assign gd_s = $signed({1'b0, cfg.gain_d});

    assign err_diff = $signed({err[E_W-1], err}) - $signed({prev_reg[E_W-1], prev_reg});

    assign p_prod = P_W'(gp_s) * P_W'(err);
    assign i_prod = P_W'(gi_s) * P_W'(err);
    assign d_prod = DP_W'(gd_s) * DP_W'(err_diff);

    // separation: integrate while |err| is inside the window, clear the accumulator outside it
    assign err_mag   = err[E_W-1] ? E_W'(-err) : E_W'(err);
    assign in_window = (MW'(err_mag) <= MW'(cfg.integral_window));

    assign acc_sum = IP_W'(acc_reg) + IP_W'(i_prod);
    assign acc_pre = in_window ? acc_sum : '0;

    assign ilim   = $signed(ACC_W'(cfg.integral_bound) << FRAC_BITS);
    assign ilim_w = IP_W'(ilim);

    always_comb
    begin
        if (acc_pre > ilim_w)
        begin
            acc_clamped = ilim;
        end
        else if (acc_pre < -ilim_w)
        begin
            acc_clamped = -ilim;
        end
        else
        begin
            acc_clamped = acc_pre[ACC_W-1:0];
        end
    end

    assign acc_next  = load ? acc_clamped : acc_reg;
    assign prev_next = load ? err : prev_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            prev_reg <= '0;
        end
        else
        begin
            acc_reg  <= acc_next;
            prev_reg <= prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            p_reg <= p_prod;
            d_reg <= d_prod;
        end
    end

    assign p_term = p_reg;
    assign d_term = d_reg;
    assign i_term = acc_reg;

endmodule

@@ rtl/core/pidisd_shape.sv @@
// ----------------------------------------------------------------------------
// pidisd_shape
// Sums the three terms, clamps to the drive bound, truncates to integer
// units and applies the dead band. Registers the result.
// ----------------------------------------------------------------------------
module pidisd_shape
    import pidisd_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
)
(
    input  logic                                clk,
    input  logic                                load,
    input  logic signed [DATA_WIDTH+GAIN_W+1:0] p_term,
    input  logic signed [DATA_WIDTH+GAIN_W+2:0] d_term,
    input  logic signed [BOUND_W+FRAC_BITS:0]   i_term,
    input  cfg_t                                cfg,
    output logic        [DRIVE_W-1:0]           drive,
    output logic                                clipped
);

    localparam int DP_W  = DATA_WIDTH + GAIN_W + 3;
    localparam int ACC_W = BOUND_W + FRAC_BITS + 1;
    localparam int SUM_W = ((DP_W > ACC_W) ? DP_W : ACC_W) + 2;

    logic [DRIVE_W-1:0]      drive_reg;
    logic [DRIVE_W-1:0]      drive_next;
    logic                    clip_reg;
    logic                    clip_next;

    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] dlim;
    logic signed [SUM_W-1:0] clamped;
    logic        [SUM_W-1:0] mag;
    logic        [BOUND_W-1:0] whole;
    logic        [BOUND_W-1:0] whole_db;

    assign sum  = SUM_W'(p_term) + SUM_W'(i_term) + SUM_W'(d_term);
    assign dlim = $signed(SUM_W'(cfg.drive_bound) << FRAC_BITS);

    always_comb
    begin
        if (sum > dlim)
        begin
            clamped   = dlim;
            clip_next = 1'b1;
        end
        else if (sum < -dlim)
        begin
            clamped   = -dlim;
            clip_next = 1'b1;
        end
        else
        begin
            clamped   = sum;
            clip_next = 1'b0;
        end
    end

    // truncate toward zero: work on the magnitude, restore the sign
    assign mag      = clamped[SUM_W-1] ? SUM_W'(-clamped) : SUM_W'(clamped);
    assign whole    = mag[FRAC_BITS +: BOUND_W];
    assign whole_db = (whole < cfg.dead_band) ? '0 : whole;
    assign drive_next = clamped[SUM_W-1] ? (DRIVE_W'(0) - {1'b0, whole_db})
                                         : {1'b0, whole_db};

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            drive_reg <= drive_next;
            clip_reg  <= clip_next;
        end
    end

    assign drive   = drive_reg;
    assign clipped = clip_reg;

endmodule

@@ rtl/core/pid_integral_separation_deadzone.sv @@
// ----------------------------------------------------------------------------
// pid_integral_separation_deadzone
// Positional PID controller in fixed point with integral separation,
// integral clamp, drive clamp and dead band.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  --------  ---  -----------------  ------------------------------------------
//  s_*       in   s_tvalid/s_tready  s_tdata: setpoint, measured
//  m_*       out  m_tvalid/m_tready  m_tdata: drive; m_tuser: clipped
//  cfg_*     in   cfg_we             cfg_index, cfg_data (no read-back)
//
//  One request per clock sustained while m_tready keeps the result side
//  draining; each request passes the error register, the term/integral stage
//  and the result register. The rate is set by the integral loop: multiply,
//  add, window select and clamp close combinationally into the accumulator.
//  Reset clears the stage valids, the previous error and the accumulator, and
//  loads the register defaults. Each stage moves on when the next one is empty
//  or emptying, so requests are still taken while a result waits downstream.
//
// ----------------------------------------------------------------------------
module pid_integral_separation_deadzone
    import pidisd_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // slave request stream
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // [DATA_WIDTH-1:0] setpoint, [2*DATA_WIDTH-1:DATA_WIDTH] measured, zero pad
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
    // master result stream
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // [15:0] drive
    output logic [DRIVE_W-1:0]      m_tdata,
    // [0] clipped
    output logic [0:0]              m_tuser,
    // configuration write port
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam int E_W = DATA_WIDTH + 1;

    // configuration registers
    cfg_t cfg_reg;
    cfg_t cfg_next;

    // pipeline control
    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;
    logic ready2, ready3;
    logic load1, load2, load3;

    // stage 1: error
    logic signed [E_W-1:0] err_reg;
    logic signed [E_W-1:0] err_next;

    // stage 2 terms
    logic signed [DATA_WIDTH+GAIN_W+1:0] p_term;
    logic signed [DATA_WIDTH+GAIN_W+2:0] d_term;
    logic signed [BOUND_W+FRAC_BITS:0]   i_term;

    logic [DRIVE_W-1:0] drive;
    logic               clipped;
    logic [DRIVE_W-1:0] drive_mag;

    // ---------------- configuration ----------------
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GAIN_P:          cfg_next.gain_p          = cfg_data[GAIN_W-1:0];
                REG_GAIN_I:          cfg_next.gain_i          = cfg_data[GAIN_W-1:0];
                REG_GAIN_D:          cfg_next.gain_d          = cfg_data[GAIN_W-1:0];
                REG_INTEGRAL_WINDOW: cfg_next.integral_window = cfg_data[WINDOW_W-1:0];
                REG_INTEGRAL_BOUND:  cfg_next.integral_bound  = cfg_data[BOUND_W-1:0];
                REG_DRIVE_BOUND:     cfg_next.drive_bound     = cfg_data[BOUND_W-1:0];
                REG_DEAD_BAND:       cfg_next.dead_band       = cfg_data[BOUND_W-1:0];
                default:             cfg_next = cfg_reg;   // unmapped index ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p          <= GAIN_RST;
            cfg_reg.gain_i          <= GAIN_RST;
            cfg_reg.gain_d          <= GAIN_RST;
            cfg_reg.integral_window <= WINDOW_RST;
            cfg_reg.integral_bound  <= BOUND_RST;
            cfg_reg.drive_bound     <= BOUND_RST;
            cfg_reg.dead_band       <= DEAD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ---------------- stage handshakes ----------------
    // each stage advances when the one after it is empty or being drained
    assign ready3   = !v3_reg || m_tready;
    assign ready2   = !v2_reg || ready3;
    assign s_tready = !v1_reg || ready2;

    assign load1 = s_tvalid && s_tready;
    assign load2 = v1_reg && ready2;
    assign load3 = v2_reg && ready3;

    assign v1_next = load1 ? 1'b1 : (load2 ? 1'b0 : v1_reg);
    assign v2_next = load2 ? 1'b1 : (load3 ? 1'b0 : v2_reg);
    assign v3_next = load3 ? 1'b1 : (m_tready ? 1'b0 : v3_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // ---------------- stage 1: error ----------------
    // bits above the two fields are padding and ignored
    assign err_next =
        $signed({s_tdata[DATA_WIDTH-1], s_tdata[DATA_WIDTH-1:0]})
      - $signed({s_tdata[2*DATA_WIDTH-1], s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]});

    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            err_reg <= err_next;
        end
    end

    // ---------------- stage 2: terms and integral ----------------
    // state (previous error, accumulator) moves exactly once per request
    pidisd_terms #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_terms (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load2),
        .err    (err_reg),
        .cfg    (cfg_reg),
        .p_term (p_term),
        .d_term (d_term),
        .i_term (i_term)
    );

    // ---------------- stage 3: sum, clamp, dead band ----------------
    pidisd_shape #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_shape (
        .clk     (clk),
        .load    (load3),
        .p_term  (p_term),
        .d_term  (d_term),
        .i_term  (i_term),
        .cfg     (cfg_reg),
        .drive   (drive),
        .clipped (clipped)
    );

    assign m_tvalid   = v3_reg;
    assign m_tdata    = drive;
    assign m_tuser[0] = clipped;

    assign drive_mag = drive[DRIVE_W-1] ? (DRIVE_W'(0) - drive) : drive;

    // ---------------- assertions ----------------
    // an empty error stage never back-pressures the slave side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !v1_reg |-> s_tready)
        else $error("s_tready low with empty input stage");

    // a nonzero drive lies between the dead band and the drive bound
    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (drive != '0)) |->
            (drive_mag >= DRIVE_W'(cfg_reg.dead_band)) &&
            (drive_mag <= DRIVE_W'(cfg_reg.drive_bound)))
        else $error("drive outside dead band / bound");

    // a clipped result sits exactly on the bound when no dead band applies
    a_clip_on_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && clipped && (cfg_reg.dead_band == '0)) |->
            (drive_mag == DRIVE_W'(cfg_reg.drive_bound)))
        else $error("clipped drive not at drive bound");

endmodule
